// ===== hw/rtl/fwht_pkg.sv =====
`default_nettype none

package fwht_pkg;

    // store geometry
    localparam int DEPTH    = 1024;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int PAIR_W   = ADDR_W - 1;
    localparam int COEF_W   = 27;
    localparam int SAMPLE_W = 16;
    localparam int LOG_W    = 4;
    localparam int REQ_W    = 2;

    // size register limits
    localparam logic [LOG_W-1:0] LOG_MIN   = LOG_W'(1);
    localparam logic [LOG_W-1:0] LOG_MAX   = LOG_W'(ADDR_W);
    localparam logic [LOG_W-1:0] LOG_RESET = LOG_W'(10);

    // request codes
    localparam logic [REQ_W-1:0] REQ_LOAD      = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TRANSFORM = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ      = 2'd2;

    // store access from the butterfly sequencer
    typedef struct packed {
        logic [ADDR_W-1:0] rd_addr_a;
        logic [ADDR_W-1:0] rd_addr_b;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [COEF_W-1:0] wr_data;
    } t_mem_req;

endpackage

`default_nettype wire

// ===== hw/rtl/fast_walsh_hadamard_transform.sv =====
`default_nettype none

// load, read, unknown requests: one per cycle unless busy; result word in the next cycle
// transform: each butterfly takes read, write-sum and write-difference states,
//   on one shared store write port; clamped log_size stages of 2^(log_size-1) butterflies
// busy stays high during a transform; the receiver cannot stall results
// synchronous active-low reset clears control and sets log_size to 10; store is not cleared
module fast_walsh_hadamard_transform (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [fwht_pkg::REQ_W-1:0]      i_req_type,
    input  wire logic [fwht_pkg::ADDR_W-1:0]     i_index,
    input  wire logic signed [fwht_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic                            i_cfg_we,
    input  wire logic [fwht_pkg::LOG_W-1:0]      i_cfg_wdata,
    output logic                                 o_valid,
    output logic signed [fwht_pkg::COEF_W-1:0]   o_coefficient,
    output logic      [fwht_pkg::REQ_W-1:0]      o_ack_kind
);

    localparam int CW = fwht_pkg::COEF_W;
    localparam int SW = fwht_pkg::SAMPLE_W;

    logic [fwht_pkg::LOG_W-1:0] r_log_size;
    logic [fwht_pkg::LOG_W-1:0] log_eff;
    logic                       r_busy, r_valid, r_is_read;
    logic [fwht_pkg::REQ_W-1:0] r_kind;
    logic                       accept, seq_done;
    fwht_pkg::t_mem_req         seq_mem;

    logic [fwht_pkg::ADDR_W-1:0] rd_addr_a, wr_addr;
    logic                        wr_en;
    logic [CW-1:0]               wr_data, rd_data_a, rd_data_b;

    assign accept = start && !r_busy;
    assign busy   = r_busy;

    // clamp size to the legal range
    always_comb begin
        priority if (r_log_size < fwht_pkg::LOG_MIN) begin
            log_eff = fwht_pkg::LOG_MIN;
        end else if (r_log_size > fwht_pkg::LOG_MAX) begin
            log_eff = fwht_pkg::LOG_MAX;
        end else begin
            log_eff = r_log_size;
        end
    end

    // store port sharing between host requests and the sequencer
    always_comb begin
        if (r_busy) begin
            rd_addr_a = seq_mem.rd_addr_a;
            wr_en     = seq_mem.wr_en;
            wr_addr   = seq_mem.wr_addr;
            wr_data   = seq_mem.wr_data;
        end else begin
            rd_addr_a = i_index;
            wr_en     = accept && (i_req_type == fwht_pkg::REQ_LOAD);
            wr_addr   = i_index;
            wr_data   = {{(CW-SW){i_sample[SW-1]}}, i_sample};
        end
    end

    fwht_store u_store (
        .i_clk       (i_clk),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (seq_mem.rd_addr_b),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b)
    );

    fwht_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (accept && (i_req_type == fwht_pkg::REQ_TRANSFORM)),
        .i_log_eff   (log_eff),
        .i_rd_data_a (rd_data_a),
        .i_rd_data_b (rd_data_b),
        .o_mem       (seq_mem),
        .o_done      (seq_done)
    );

    // size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_size <= fwht_pkg::LOG_RESET;
        end else if (i_cfg_we) begin
            r_log_size <= i_cfg_wdata;
        end
    end

    // busy flag and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (accept) begin
                if (i_req_type == fwht_pkg::REQ_TRANSFORM) begin
                    r_busy <= 1'b1;
                end else begin
                    r_valid <= 1'b1;
                end
            end else if (r_busy && seq_done) begin
                r_busy  <= 1'b0;
                r_valid <= 1'b1;
            end
        end
    end

    // result word fields
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind    <= i_req_type;
            r_is_read <= (i_req_type == fwht_pkg::REQ_READ);
        end else if (r_busy && seq_done) begin
            r_kind    <= fwht_pkg::REQ_TRANSFORM;
            r_is_read <= 1'b0;
        end
    end

    assign o_valid       = r_valid;
    assign o_ack_kind    = r_kind;
    assign o_coefficient = r_is_read ? rd_data_a : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/fwht_store.sv =====
`default_nettype none

module fwht_store (
    input  wire logic                          i_clk,
    input  wire logic [fwht_pkg::ADDR_W-1:0]   i_rd_addr_a,
    input  wire logic [fwht_pkg::ADDR_W-1:0]   i_rd_addr_b,
    input  wire logic                          i_wr_en,
    input  wire logic [fwht_pkg::ADDR_W-1:0]   i_wr_addr,
    input  wire logic [fwht_pkg::COEF_W-1:0]   i_wr_data,
    output logic      [fwht_pkg::COEF_W-1:0]   o_rd_data_a,
    output logic      [fwht_pkg::COEF_W-1:0]   o_rd_data_b
);

    logic [fwht_pkg::COEF_W-1:0] r_mem [fwht_pkg::DEPTH];

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // two registered read ports
    always_ff @(posedge i_clk) begin
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fwht_seq.sv =====
`default_nettype none

module fwht_seq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [fwht_pkg::LOG_W-1:0]    i_log_eff,
    input  wire logic [fwht_pkg::COEF_W-1:0]   i_rd_data_a,
    input  wire logic [fwht_pkg::COEF_W-1:0]   i_rd_data_b,
    output fwht_pkg::t_mem_req                 o_mem,
    output logic                               o_done
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_WA   = 2'd2;
    localparam logic [1:0] ST_WB   = 2'd3;

    localparam int CW = fwht_pkg::COEF_W;
    localparam int AW = fwht_pkg::ADDR_W;
    localparam int PW = fwht_pkg::PAIR_W;

    logic [1:0]                      r_state, n_state;
    logic [fwht_pkg::LOG_W-1:0]      r_stage, n_stage;
    logic [PW-1:0]                   r_pair, n_pair;
    logic [PW-1:0]                   r_last, n_last;
    logic [CW-1:0]                   r_diff, n_diff;

    logic [AW-1:0] span, mask, pair_ext, lo_idx, hi_idx;
    logic [CW:0]   sum_w, dif_w;
    logic [CW-1:0] sum_s, dif_s;
    logic [fwht_pkg::LOG_W-1:0] top_stage;

    function automatic logic [CW-1:0] sat(input logic [CW:0] v);
        logic [CW-1:0] res;
        if (v[CW] != v[CW-1]) begin
            res = v[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end else begin
            res = v[CW-1:0];
        end
        return res;
    endfunction

    // pair index with a zero inserted at the stage bit
    always_comb begin
        span     = AW'(1) << r_stage;
        mask     = span - AW'(1);
        pair_ext = {1'b0, r_pair};
        lo_idx   = ((pair_ext & ~mask) << 1) | (pair_ext & mask);
        hi_idx   = lo_idx | span;
    end

    // butterfly arithmetic
    always_comb begin
        sum_w = {i_rd_data_a[CW-1], i_rd_data_a} + {i_rd_data_b[CW-1], i_rd_data_b};
        dif_w = {i_rd_data_a[CW-1], i_rd_data_a} - {i_rd_data_b[CW-1], i_rd_data_b};
        sum_s = sat(sum_w);
        dif_s = sat(dif_w);
    end

    // sequencer next state
    always_comb begin
        n_state   = r_state;
        n_stage   = r_stage;
        n_pair    = r_pair;
        n_last    = r_last;
        n_diff    = r_diff;
        o_done    = 1'b0;
        top_stage = i_log_eff - fwht_pkg::LOG_W'(1);

        o_mem.rd_addr_a = lo_idx;
        o_mem.rd_addr_b = hi_idx;
        o_mem.wr_en     = 1'b0;
        o_mem.wr_addr   = lo_idx;
        o_mem.wr_data   = sum_s;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_stage = top_stage;
                    n_pair  = '0;
                    n_last  = PW'((AW'(1) << top_stage) - AW'(1));
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                n_state = ST_WA;
            end
            ST_WA: begin
                o_mem.wr_en = 1'b1;
                n_diff      = dif_s;
                n_state     = ST_WB;
            end
            ST_WB: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_addr = hi_idx;
                o_mem.wr_data = r_diff;
                if (r_pair == r_last) begin
                    n_pair = '0;
                    if (r_stage == '0) begin
                        o_done  = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_stage = r_stage - fwht_pkg::LOG_W'(1);
                        n_state = ST_RD;
                    end
                end else begin
                    n_pair  = r_pair + PW'(1);
                    n_state = ST_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // counters and held difference
    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
        r_pair  <= n_pair;
        r_last  <= n_last;
        r_diff  <= n_diff;
    end

endmodule

`default_nettype wire

// ===== test/tb_fast_walsh_hadamard_transform.sv =====
`timescale 1ns / 100ps

module tb_fast_walsh_hadamard_transform;

    localparam int WORD_TARGET    = 1350;
    localparam int WATCHDOG_LIMIT = 50000;
    localparam int FILL_ALL_MAX   = 64;
    localparam int BIG_POINTS     = 256;

    localparam logic [fwht_pkg::REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    localparam longint COEF_HI = (longint'(1) << (fwht_pkg::COEF_W - 1)) - 1;
    localparam longint COEF_LO = -(longint'(1) << (fwht_pkg::COEF_W - 1));

    // one acknowledgement word as the block should return it
    typedef struct {
        logic signed [fwht_pkg::COEF_W-1:0] coef;
        logic [fwht_pkg::REQ_W-1:0]         kind;
    } t_ack;

    // shadow copy of the coefficient store plus the acks still owed
    class t_coef_tracker;
        logic signed [fwht_pkg::COEF_W-1:0] coefs [fwht_pkg::DEPTH];
        logic [fwht_pkg::LOG_W-1:0]         log_size;
        t_ack                               acks_due [$];
        int                                 mismatches;

        function new();
            log_size   = fwht_pkg::LOG_RESET;
            mismatches = 0;
            foreach (coefs[i]) coefs[i] = '0;
        endfunction

        // out-of-range sizes clamp to the legal span
        function int unsigned points_for(logic [fwht_pkg::LOG_W-1:0] raw);
            int unsigned k;
            k = raw;
            if (k < fwht_pkg::LOG_MIN) k = fwht_pkg::LOG_MIN;
            if (k > fwht_pkg::LOG_MAX) k = fwht_pkg::LOG_MAX;
            return 1 << k;
        endfunction

        function logic signed [fwht_pkg::COEF_W-1:0] clip(longint v);
            if (v > COEF_HI) return fwht_pkg::COEF_W'(COEF_HI);
            if (v < COEF_LO) return fwht_pkg::COEF_W'(COEF_LO);
            return fwht_pkg::COEF_W'(v);
        endfunction

        // in-place radix-2 stages, span halving down to 1
        function void butterfly_all();
            int unsigned n, span, blk, z;
            longint a, b;
            n = points_for(log_size);
            for (span = n >> 1; span >= 1; span >>= 1) begin
                for (blk = 0; blk < n; blk += 2 * span) begin
                    for (z = blk; z < blk + span; z++) begin
                        a = coefs[z];
                        b = coefs[z + span];
                        coefs[z]        = clip(a + b);
                        coefs[z + span] = clip(a - b);
                    end
                end
            end
        endfunction

        function void write_log_size(logic [fwht_pkg::LOG_W-1:0] v);
            log_size = v;
        endfunction

        function void note_request(logic [fwht_pkg::REQ_W-1:0] kind,
                                   logic [fwht_pkg::ADDR_W-1:0] idx,
                                   logic signed [fwht_pkg::SAMPLE_W-1:0] smp);
            t_ack due;
            due.kind = kind;
            due.coef = '0;
            case (kind)
                fwht_pkg::REQ_LOAD:      coefs[idx] = smp;
                fwht_pkg::REQ_TRANSFORM: butterfly_all();
                fwht_pkg::REQ_READ:      due.coef = coefs[idx];
                default:                 ;
            endcase
            acks_due.push_back(due);
        endfunction

        function void check_ack(logic signed [fwht_pkg::COEF_W-1:0] coef,
                                logic [fwht_pkg::REQ_W-1:0] kind);
            t_ack due;
            if (acks_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: coefficient %0d kind %0d", coef, kind);
                return;
            end
            due = acks_due.pop_front();
            if (coef !== due.coef || kind !== due.kind) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("word mismatch: expected coefficient %0d kind %0d, got %0d kind %0d",
                             due.coef, due.kind, coef, kind);
            end
        endfunction

        function int unsigned words_due();
            return acks_due.size();
        endfunction
    endclass

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 start;
    logic                                 busy;
    logic [fwht_pkg::REQ_W-1:0]           i_req_type;
    logic [fwht_pkg::ADDR_W-1:0]          i_index;
    logic signed [fwht_pkg::SAMPLE_W-1:0] i_sample;
    logic                                 i_cfg_we;
    logic [fwht_pkg::LOG_W-1:0]           i_cfg_wdata;
    logic                                 o_valid;
    logic signed [fwht_pkg::COEF_W-1:0]   o_coefficient;
    logic [fwht_pkg::REQ_W-1:0]           o_ack_kind;

    t_coef_tracker sb;
    bit          written [fwht_pkg::DEPTH];
    int unsigned cur_points = fwht_pkg::DEPTH;
    int          words_sent = 0;
    bit          no_gaps    = 1'b0;
    int          idle_cycles = 0;
    bit          progress;

    fast_walsh_hadamard_transform dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_index       (i_index),
        .i_sample      (i_sample),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_valid       (o_valid),
        .o_coefficient (o_coefficient),
        .o_ack_kind    (o_ack_kind)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // accepted words in, acks out, register writes, and the stall watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            progress = 1'b0;
            if (o_valid) begin
                sb.check_ack(o_coefficient, o_ack_kind);
                progress = 1'b1;
            end
            if (start && !busy) begin
                sb.note_request(i_req_type, i_index, i_sample);
                progress = 1'b1;
            end
            if (i_cfg_we) sb.write_log_size(i_cfg_wdata);
            idle_cycles = progress ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // extremes often, otherwise anything
    function automatic logic [fwht_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return fwht_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    // prefer entries that were loaded at some point, else any index in the current span
    function automatic logic [fwht_pkg::ADDR_W-1:0] written_index();
        int unsigned idx;
        repeat (4) begin
            idx = $urandom_range(0, fwht_pkg::DEPTH - 1);
            if (written[idx]) return fwht_pkg::ADDR_W'(idx);
        end
        return fwht_pkg::ADDR_W'($urandom_range(0, cur_points - 1));
    endfunction

    // hold start with the word until the block takes it
    task automatic send_word(input logic [fwht_pkg::REQ_W-1:0] kind,
                             input logic [fwht_pkg::ADDR_W-1:0] idx,
                             input logic [fwht_pkg::SAMPLE_W-1:0] smp);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_req_type <= kind;
        i_index    <= idx;
        i_sample   <= smp;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (kind == fwht_pkg::REQ_LOAD) written[idx] = 1'b1;
        if (kind != REQ_UNKNOWN) words_sent++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.words_due() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic set_size(input logic [fwht_pkg::LOG_W-1:0] v);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_points = sb.points_for(v);
    endtask

    // new size, fill the transform span, then a random mix of words
    task automatic run_phase(input logic [fwht_pkg::LOG_W-1:0] cfg, input int body_words);
        int order [FILL_ALL_MAX];
        int pick, tmp, transforms, r;
        set_size(cfg);
        no_gaps = ($urandom_range(0, 3) == 0);
        if (cur_points <= FILL_ALL_MAX) begin
            for (int i = 0; i < cur_points; i++) order[i] = i;
            for (int i = cur_points - 1; i > 0; i--) begin
                pick        = $urandom_range(0, i);
                tmp         = order[i];
                order[i]    = order[pick];
                order[pick] = tmp;
            end
            for (int i = 0; i < cur_points; i++)
                send_word(fwht_pkg::REQ_LOAD, fwht_pkg::ADDR_W'(order[i]), pick_sample());
        end else begin
            for (int i = 0; i < cur_points; i++)
                if (!written[i])
                    send_word(fwht_pkg::REQ_LOAD, fwht_pkg::ADDR_W'(i), pick_sample());
        end
        transforms = 0;
        repeat (body_words) begin
            r = $urandom_range(0, 99);
            if (r >= 70 && r < 85 && (cur_points < BIG_POINTS || transforms < 2)) begin
                transforms++;
                send_word(fwht_pkg::REQ_TRANSFORM, fwht_pkg::ADDR_W'($urandom),
                          fwht_pkg::SAMPLE_W'($urandom));
            end else if (r < 35) begin
                if ($urandom_range(0, 1))
                    send_word(fwht_pkg::REQ_LOAD,
                              fwht_pkg::ADDR_W'($urandom_range(0, cur_points - 1)),
                              pick_sample());
                else
                    send_word(fwht_pkg::REQ_LOAD, fwht_pkg::ADDR_W'($urandom),
                              pick_sample());
            end else if (r < 85) begin
                send_word(fwht_pkg::REQ_READ, written_index(), fwht_pkg::SAMPLE_W'($urandom));
            end else begin
                send_word(REQ_UNKNOWN, fwht_pkg::ADDR_W'($urandom),
                          fwht_pkg::SAMPLE_W'($urandom));
            end
        end
    endtask

    // stimulus
    initial begin
        int phase;
        logic [fwht_pkg::LOG_W-1:0] cfg;

        sb = new();
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_req_type  <= fwht_pkg::REQ_LOAD;
        i_index     <= '0;
        i_sample    <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // size zero clamps to two points
        set_size(4'd0);
        send_word(fwht_pkg::REQ_LOAD, 10'd0, 16'h8000);
        send_word(fwht_pkg::REQ_LOAD, 10'd1, 16'h7FFF);
        send_word(fwht_pkg::REQ_READ, 10'd0, 16'h0000);
        send_word(fwht_pkg::REQ_READ, 10'd1, 16'hFFFF);
        send_word(fwht_pkg::REQ_TRANSFORM, 10'h3FF, 16'hFFFF);
        send_word(fwht_pkg::REQ_READ, 10'd0, 16'h0000);
        send_word(fwht_pkg::REQ_READ, 10'd1, 16'h0000);
        send_word(REQ_UNKNOWN, 10'h3FF, 16'h8000);
        send_word(REQ_UNKNOWN, 10'h000, 16'h0000);
        // loads and reads reach past the transform span
        send_word(fwht_pkg::REQ_LOAD, 10'h3FF, 16'hFFFF);
        send_word(fwht_pkg::REQ_READ, 10'h3FF, 16'h0000);
        // repeated transform without reload
        send_word(fwht_pkg::REQ_TRANSFORM, 10'h000, 16'h0000);
        send_word(fwht_pkg::REQ_READ, 10'd0, 16'h0000);
        send_word(fwht_pkg::REQ_READ, 10'd1, 16'h0000);

        // four points, two of them carried over
        set_size(4'd2);
        send_word(fwht_pkg::REQ_LOAD, 10'd2, 16'h5555);
        send_word(fwht_pkg::REQ_LOAD, 10'd3, 16'hAAAA);
        send_word(fwht_pkg::REQ_TRANSFORM, 10'h155, 16'h2AAA);
        for (int i = 0; i < 4; i++)
            send_word(fwht_pkg::REQ_READ, fwht_pkg::ADDR_W'(i), 16'h0000);

        // full store at the top size; repeated passes drive the butterflies into saturation
        run_phase(4'd15, 0);
        repeat (3) begin
            send_word(fwht_pkg::REQ_TRANSFORM, fwht_pkg::ADDR_W'($urandom),
                      fwht_pkg::SAMPLE_W'($urandom));
            repeat (4)
                send_word(fwht_pkg::REQ_READ, written_index(), fwht_pkg::SAMPLE_W'($urandom));
        end

        // random phases, mostly small sizes
        phase = 0;
        while (words_sent < WORD_TARGET) begin
            case (phase)
                0:       cfg = fwht_pkg::LOG_MIN;
                1:       cfg = fwht_pkg::LOG_MAX;
                default: cfg = ($urandom_range(0, 7) == 0)
                               ? fwht_pkg::LOG_W'($urandom_range(7, 15))
                               : fwht_pkg::LOG_W'($urandom_range(0, 6));
            endcase
            run_phase(cfg, $urandom_range(10, 40));
            phase++;
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.words_due() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
